/* design/pprs_pkg.sv */
package pprs_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int QUANTUM_W     = 4;
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 4'd2;

    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic [3:0] RUN_MAX = 4'hF;

    // one table entry: kept sorted by prio, FIFO among equal prio
    typedef struct packed {
        logic [3:0] id;
        logic [7:0] prio;
        logic [7:0] left;
        logic [3:0] run;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic       kind;
        logic [3:0] job_id;
        logic [7:0] job_priority;
        logic [7:0] job_burst;
    } in_item_t;

    typedef struct packed {
        logic       arrival_preempts;
        logic       rotated;
        logic [3:0] preempted_job;
        logic       table_full;
        logic       finished_valid;
        logic [3:0] finished_job;
        logic       run_valid;
        logic [3:0] run_job;
        logic       context_switch;
        logic       queue_empty;
    } res_item_t;

endpackage

/* design/preemptive_priority_rr_scheduler_core.sv */
// Channel   Signals                      Transfer
// input     start, busy, item            start & !busy at a rising edge
// result    done, result                 done high for one cycle, no back pressure
// config    cfg_valid, cfg_ready, cfg_data   cfg_valid & cfg_ready (ready always high)
//
// One sequencer walks the job table in a single-port-read RAM, each entry in a read
// step (address), then an evaluate step (compare and write back). An arrival shifts
// the entries that rank below it down one place and writes itself into the gap; a
// full table or an empty tick is answered without going busy. A tick may retire the
// head, rotate it and then run it. Reset clears the entry count and state; table
// contents need no clearing. The result is registered from the last step and appears
// while busy is already low, so the next item may start in that same cycle.
module preemptive_priority_rr_scheduler_core #(
    parameter int SLOTS = pprs_pkg::SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pprs_pkg::in_item_t             item,
    output logic                           done,
    output pprs_pkg::res_item_t            result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pprs_pkg::QUANTUM_W-1:0] cfg_data
);

    import pprs_pkg::*;

    localparam int AW = $clog2(SLOTS);

    logic [QUANTUM_W-1:0] quantum_reg;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic [AW-1:0]        rd_addr;
    logic [ENTRY_W-1:0]   rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            quantum_reg <= cfg_data;
        end
    end

    pprs_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .quantum (quantum_reg),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pprs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

/* design/pprs_ram.sv */
module pprs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* design/pprs_ctrl.sv */
module pprs_ctrl #(
    parameter int SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  pprs_pkg::in_item_t           item,
    input  logic [pprs_pkg::QUANTUM_W-1:0] quantum,
    output logic                         busy,
    output logic                         done,
    output pprs_pkg::res_item_t          result,
    output logic                         wr_en,
    output logic [$clog2(SLOTS)-1:0]     wr_addr,
    output logic [pprs_pkg::ENTRY_W-1:0] wr_data,
    output logic [$clog2(SLOTS)-1:0]     rd_addr,
    input  logic [pprs_pkg::ENTRY_W-1:0] rd_data
);

    import pprs_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_INS_RD = 12'b0000_0000_0010,
        S_INS_EV = 12'b0000_0000_0100,
        S_INS_WR = 12'b0000_0000_1000,
        S_HD_RD  = 12'b0000_0001_0000,
        S_HD_EV  = 12'b0000_0010_0000,
        S_RM_RD  = 12'b0000_0100_0000,
        S_RM_EV  = 12'b0000_1000_0000,
        S_ROT_RD = 12'b0001_0000_0000,
        S_ROT_EV = 12'b0010_0000_0000,
        S_ROT_WR = 12'b0100_0000_0000,
        S_RUN_WR = 12'b1000_0000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [AW-1:0]   wpos_reg, wpos_next;
    logic            done_reg, done_next;
    logic            ret_done_reg, ret_done_next;
    logic            rot_done_reg, rot_done_next;
    entry_t          hd_reg, hd_next;
    entry_t          new_reg, new_next;
    res_item_t       res_reg, res_next;

    entry_t          rd_entry;
    entry_t          hd_run;
    entry_t          hd_rot;
    logic [CW-1:0]   count_dec;
    logic [AW-1:0]   cnt_m1;
    logic [AW-1:0]   ptr_inc;
    logic [AW-1:0]   ptr_dec;
    logic [CW-1:0]   ptr_w;

    assign rd_entry  = entry_t'(rd_data);
    assign count_dec = count_reg - CW'(1);
    assign cnt_m1    = count_dec[AW-1:0];
    assign ptr_inc   = ptr_reg + AW'(1);
    assign ptr_dec   = ptr_reg - AW'(1);
    assign ptr_w     = CW'(ptr_reg);

    // head after one unit of run: time left stops at zero, run count saturates
    always_comb
    begin
        hd_run      = hd_reg;
        hd_run.left = (hd_reg.left == 8'd0) ? 8'd0 : hd_reg.left - 8'd1;
        hd_run.run  = (hd_reg.run == RUN_MAX) ? RUN_MAX : hd_reg.run + 4'd1;
        hd_rot      = hd_reg;
        hd_rot.run  = 4'd0;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        wpos_next     = wpos_reg;
        done_next     = 1'b0;
        ret_done_next = ret_done_reg;
        rot_done_next = rot_done_reg;
        hd_next       = hd_reg;
        new_next      = new_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        wr_addr       = ptr_reg;
        wr_data       = rd_data;
        rd_addr       = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next      = '0;
                    ret_done_next = 1'b0;
                    rot_done_next = 1'b0;
                    if (item.kind == KIND_ARRIVE)
                    begin
                        if (count_reg == CW'(SLOTS))
                        begin
                            res_next.table_full = 1'b1;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            new_next.id   = item.job_id;
                            new_next.prio = item.job_priority;
                            new_next.left = item.job_burst;
                            new_next.run  = 4'd0;
                            count_next    = count_reg + CW'(1);
                            if (count_reg == '0)
                            begin
                                wpos_next  = '0;
                                state_next = S_INS_WR;
                            end
                            else
                            begin
                                // scan from the tail toward the head
                                ptr_next   = cnt_m1;
                                state_next = S_INS_RD;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_HD_RD;
                        end
                    end
                end
            end

            S_INS_RD:
            begin
                state_next = S_INS_EV;
            end

            S_INS_EV:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_inc;
                if (rd_entry.prio > new_reg.prio)
                begin
                    wr_data = rd_data;
                    if (ptr_reg == '0)
                    begin
                        // new job lands at the head: it outranks the old head
                        res_next.arrival_preempts = 1'b1;
                        res_next.preempted_job    = rd_entry.id;
                        wpos_next  = '0;
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        ptr_next   = ptr_dec;
                        state_next = S_INS_RD;
                    end
                end
                else
                begin
                    wr_data    = ENTRY_W'(new_reg);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = wpos_reg;
                wr_data    = ENTRY_W'(new_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_HD_RD:
            begin
                rd_addr    = '0;
                state_next = S_HD_EV;
            end

            S_HD_EV:
            begin
                hd_next       = rd_entry;
                ret_done_next = 1'b1;
                if (!ret_done_reg && rd_entry.left == 8'd0)
                begin
                    res_next.finished_valid = 1'b1;
                    res_next.finished_job   = rd_entry.id;
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        res_next.context_switch = 1'b1;
                        ptr_next   = AW'(1);
                        state_next = S_RM_RD;
                    end
                end
                else if (!rot_done_reg && count_reg > CW'(1) && rd_entry.run >= quantum)
                begin
                    rot_done_next = 1'b1;
                    ptr_next      = AW'(1);
                    state_next    = S_ROT_RD;
                end
                else
                begin
                    state_next = S_RUN_WR;
                end
            end

            S_RM_RD:
            begin
                state_next = S_RM_EV;
            end

            S_RM_EV:
            begin
                // close the gap left by the retired head; count already reduced
                wr_en   = 1'b1;
                wr_addr = ptr_dec;
                wr_data = rd_data;
                if (ptr_w == count_reg)
                begin
                    state_next = S_HD_RD;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_RM_RD;
                end
            end

            S_ROT_RD:
            begin
                state_next = S_ROT_EV;
            end

            S_ROT_EV:
            begin
                if (rd_entry.prio == hd_reg.prio)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ptr_dec;
                    wr_data = rd_data;
                    res_next.rotated       = 1'b1;
                    res_next.preempted_job = hd_reg.id;
                    if (ptr_w == count_dec)
                    begin
                        wpos_next  = ptr_reg;
                        state_next = S_ROT_WR;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        state_next = S_ROT_RD;
                    end
                end
                else if (ptr_reg == AW'(1))
                begin
                    // no equal-priority peer: head keeps running
                    state_next = S_RUN_WR;
                end
                else
                begin
                    wpos_next  = ptr_dec;
                    state_next = S_ROT_WR;
                end
            end

            S_ROT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = wpos_reg;
                wr_data    = ENTRY_W'(hd_rot);
                state_next = S_HD_RD;
            end

            S_RUN_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = ENTRY_W'(hd_run);
                res_next.run_valid = 1'b1;
                res_next.run_job   = hd_reg.id;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            res_next.queue_empty = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            ret_done_reg <= 1'b0;
            rot_done_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            ret_done_reg <= ret_done_next;
            rot_done_reg <= rot_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        wpos_reg <= wpos_next;
        hd_reg   <= hd_next;
        new_reg  <= new_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* design/pprs_checker.sv */
module pprs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input pprs_pkg::res_item_t result
);

    import pprs_pkg::*;

    // result strobe only comes once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted item either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither busy nor done");

    // leaving busy always delivers the item's result
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // no result without preceding work
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start && !busy)))
        else $error("result without an item");

    // a dropped arrival reports nothing else
    a_full_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |-> (!result.arrival_preempts && !result.run_valid
            && !result.finished_valid && !result.rotated))
        else $error("dropped arrival with other activity");

endmodule

bind preemptive_priority_rr_scheduler_core pprs_checker u_pprs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

/* test/tb_preemptive_priority_rr_scheduler_core.sv */
`timescale 1ns / 1ps

module tb_preemptive_priority_rr_scheduler_core;
    import pprs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        in_item_t  it;
        bit        pin;
        res_item_t res;
    } row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  item;
    logic      done;
    res_item_t result;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [QUANTUM_W-1:0] cfg_data;

    // pinned expectation travels with the item, sampled at acceptance
    logic      pin_on;
    res_item_t pin_res;

    // scheduler shadow state
    entry_t          jobs [SLOTS_DEF];
    int              njobs = 0;
    logic [3:0]      quantum_now = QUANTUM_RESET;

    res_item_t outcome_q [$];
    row_t      directed_rows [$];
    int        errors = 0;
    int        cycles = 0;

    preemptive_priority_rr_scheduler_core #(.SLOTS(SLOTS_DEF)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, outcome_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic res_item_t schedule_step(in_item_t it);
        res_item_t r;
        entry_t    h;
        int        pos;
        int        i;
        r = '0;
        if (it.kind == KIND_ARRIVE)
        begin
            if (njobs >= SLOTS_DEF)
                r.table_full = 1'b1;
            else
            begin
                if (njobs > 0 && it.job_priority < jobs[0].prio)
                begin
                    r.arrival_preempts = 1'b1;
                    r.preempted_job    = jobs[0].id;
                end
                pos = 0;
                while (pos < njobs && jobs[pos].prio <= it.job_priority)
                    pos++;
                for (i = njobs; i > pos; i--)
                    jobs[i] = jobs[i-1];
                jobs[pos].id   = it.job_id;
                jobs[pos].prio = it.job_priority;
                jobs[pos].left = it.job_burst;
                jobs[pos].run  = '0;
                njobs++;
            end
        end
        else
        begin
            if (njobs > 0 && jobs[0].left == 0)
            begin
                r.finished_valid = 1'b1;
                r.finished_job   = jobs[0].id;
                for (i = 1; i < njobs; i++)
                    jobs[i-1] = jobs[i];
                njobs--;
                if (njobs > 0)
                    r.context_switch = 1'b1;
            end
            // rotate behind the last peer of equal priority
            if (njobs > 1 && jobs[0].run >= quantum_now && jobs[1].prio == jobs[0].prio)
            begin
                h   = jobs[0];
                pos = 1;
                while (pos < njobs && jobs[pos].prio == h.prio)
                    pos++;
                for (i = 1; i < pos; i++)
                    jobs[i-1] = jobs[i];
                h.run       = '0;
                jobs[pos-1] = h;
                r.rotated       = 1'b1;
                r.preempted_job = h.id;
            end
            if (njobs > 0)
            begin
                r.run_valid = 1'b1;
                r.run_job   = jobs[0].id;
                if (jobs[0].left != 0)
                    jobs[0].left--;
                if (jobs[0].run < RUN_MAX)
                    jobs[0].run++;
            end
        end
        r.queue_empty = (njobs == 0);
        return r;
    endfunction

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_outcome(input res_item_t want, input res_item_t got);
        cmp_field("arrival_preempts", want.arrival_preempts, got.arrival_preempts);
        cmp_field("rotated", want.rotated, got.rotated);
        cmp_field("preempted_job", want.preempted_job, got.preempted_job);
        cmp_field("table_full", want.table_full, got.table_full);
        cmp_field("finished_valid", want.finished_valid, got.finished_valid);
        cmp_field("finished_job", want.finished_job, got.finished_job);
        cmp_field("run_valid", want.run_valid, got.run_valid);
        cmp_field("run_job", want.run_job, got.run_job);
        cmp_field("context_switch", want.context_switch, got.context_switch);
        cmp_field("queue_empty", want.queue_empty, got.queue_empty);
    endtask

    always @(posedge clk)
    begin : monitor
        res_item_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none got %h", $time, result);
                    errors++;
                end
                else
                    check_outcome(outcome_q.pop_front(), result);
            end
            if (start && !busy)
            begin
                want = schedule_step(item);
                if (pin_on)
                    want = pin_res;
                outcome_q.insert(outcome_q.size(), want);
            end
        end
    end

    task automatic add_row(input logic k, input int id, input int pr, input int bu,
                           input bit pin = 1'b0, input res_item_t res = '0);
        row_t r;
        r.it.kind         = k;
        r.it.job_id       = 4'(id);
        r.it.job_priority = 8'(pr);
        r.it.job_burst    = 8'(bu);
        r.pin             = pin;
        r.res             = res;
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // start stays high across back-to-back items; lowered only for a gap or by wait_quiet
    task automatic send_item(input in_item_t it, input int gap, input bit pin,
                             input res_item_t res);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        item    <= it;
        pin_on  <= pin;
        pin_res <= res;
        do @(posedge clk); while (busy);
    endtask

    task automatic wait_quiet(input int settle);
        start <= 1'b0;
        @(posedge clk);
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_quantum(input logic [3:0] q);
        cfg_data  <= q;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        quantum_now  = q;
    endtask

    function automatic in_item_t random_request(input int pct, input int span, input int bmax);
        in_item_t r;
        r.kind         = ($urandom_range(0, 99) < pct) ? KIND_ARRIVE : KIND_TICK;
        r.job_id       = 4'($urandom_range(0, 15));
        r.job_priority = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, span));
        r.job_burst    = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, bmax));
        return r;
    endfunction

    initial
    begin : stimulus
        res_item_t  r;
        in_item_t   it;
        int         ph;
        int         n;
        int         gap;
        bit         idle_ok;
        int         pct;
        int         span;
        int         bmax;
        logic [3:0] q;

        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        pin_on    = 1'b0;
        pin_res   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table tick, then preemption, zero burst and rotation at reset quantum
        r = '0;
        r.queue_empty = 1'b1;
        add_row(KIND_TICK, 0, 0, 0, 1'b1, r);
        add_row(KIND_ARRIVE, 15, 255, 255, 1'b1, '0);
        r = '0;
        r.arrival_preempts = 1'b1;
        r.preempted_job    = 4'd15;
        add_row(KIND_ARRIVE, 0, 0, 1, 1'b1, r);
        add_row(KIND_ARRIVE, 5, 0, 0);
        add_row(KIND_TICK, 9, 9, 9);
        add_row(KIND_TICK, 0, 0, 0);       // retire, next head holds no time
        add_row(KIND_TICK, 15, 255, 255);
        add_row(KIND_ARRIVE, 10, 255, 3);
        add_row(KIND_TICK, 0, 0, 0);
        add_row(KIND_TICK, 0, 0, 0);       // quantum reached, rotate
        add_row(KIND_TICK, 0, 0, 0);
        for (n = 0; n < 14; n++)
            add_row(KIND_ARRIVE, n + 1, n * 18, n % 3);
        r = '0;
        r.table_full = 1'b1;
        add_row(KIND_ARRIVE, 3, 0, 7, 1'b1, r);

        foreach (directed_rows[k])
        begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 11) : 0;
            send_item(directed_rows[k].it, gap, directed_rows[k].pin, directed_rows[k].res);
        end

        for (ph = 0; ph < 6; ph++)
        begin
            wait_quiet(10);
            unique case (ph)
                0: begin q = 4'd0;  pct = 35; span = 2; bmax = 6;  end
                1: begin q = 4'd1;  pct = 30; span = 3; bmax = 8;  end
                2: begin q = 4'd15; pct = 20; span = 1; bmax = 40; end
                3: begin q = 4'($urandom_range(1, 14)); pct = 30; span = 7; bmax = 10; end
                4: begin q = 4'($urandom_range(0, 15)); pct = $urandom_range(15, 45);
                         span = 3; bmax = 12; end
                default: begin q = 4'd2; pct = 30; span = 2; bmax = 6; end
            endcase
            write_quantum(q);
            for (n = 0; n < 125; n++)
            begin
                idle_ok = (ph != 5) && ((n / 40) % 3 != 2);
                gap = (idle_ok && $urandom_range(0, 2) == 0) ? $urandom_range(1, 11) : 0;
                it  = random_request(pct, span, bmax);
                send_item(it, gap, 1'b0, '0);
            end
        end

        wait_quiet(80);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
